// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that can be compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// implication whose property is checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("assertion failed");
// implication in the same cycle
`define ASSERT_NOW(label, clk, rst_n, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_NEXT(label, clk, rst_n, trig, prop)
`define ASSERT_NOW(label, clk, rst_n, trig, prop)
`endif
`endif

// ===== rtl/gtfws_pkg.sv =====
// ----------------------------------------------------------------------------
// gtfws_pkg
// shared types, constants and the arctangent table of the wheel speed mixer
// ----------------------------------------------------------------------------
`default_nettype none

package gtfws_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_TABLE_LEN = 24;
    localparam int INV_GAIN         = 39797;
    localparam int PROJ_W           = 26;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;

    localparam logic [14:0] SPEED_LIMIT_RST = 15'd256;
    localparam logic [15:0] INV_CIRC_RST    = 16'd4096;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_LIMIT = 3'd0,
        REG_INV_CIRC    = 3'd1,
        REG_FL_LEVER    = 3'd2,
        REG_FR_LEVER    = 3'd3,
        REG_BL_LEVER    = 3'd4,
        REG_BR_LEVER    = 3'd5
    } cfg_idx_t;

    // motion vector with its heading
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        heading;
    } vec_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] a;
        case (i)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            23: a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gtfws_cmd_if.sv =====
// ----------------------------------------------------------------------------
// gtfws_cmd_if
// request channel carrying the motion vector and heading
// ----------------------------------------------------------------------------
`default_nettype none

interface gtfws_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic [15:0]        heading;

    modport source (output valid, output grad_x, output grad_y, output heading, input ready);
    modport sink (input valid, input grad_x, input grad_y, input heading, output ready);
endinterface

`default_nettype wire

// ===== rtl/gtfws_spd_if.sv =====
// ----------------------------------------------------------------------------
// gtfws_spd_if
// result channel carrying the four wheel speeds
// ----------------------------------------------------------------------------
`default_nettype none

interface gtfws_spd_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] front_left_speed;
    logic signed [23:0] front_right_speed;
    logic signed [23:0] back_left_speed;
    logic signed [23:0] back_right_speed;

    modport source (output valid, output front_left_speed, output front_right_speed,
                    output back_left_speed, output back_right_speed, input ready);
    modport sink (input valid, input front_left_speed, input front_right_speed,
                  input back_left_speed, input back_right_speed, output ready);
endinterface

`default_nettype wire

// ===== rtl/gtfws_limit.sv =====
// ----------------------------------------------------------------------------
// gtfws_limit
// pipelined length limiter: square sum, 24-stage square root, 16-stage divide
// ----------------------------------------------------------------------------
`default_nettype none

module gtfws_limit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire gtfws_pkg::vec_t in_vec,
    input  wire logic [14:0]     speed_limit,
    output logic                 out_valid,
    output gtfws_pkg::vec_t      out_vec
);
    import gtfws_pkg::*;

    localparam int SQ_STEPS  = 24;
    localparam int DIV_STEPS = 16;

    typedef struct packed {
        vec_t        v;
        logic [30:0] sqx;
        logic [30:0] sqy;
        logic [29:0] nx;
        logic [29:0] ny;
    } pre_t;

    typedef struct packed {
        vec_t        v;
        logic        big;
        logic        lzero;
        logic [31:0] s2;
        logic [26:0] rem;
        logic [23:0] root;
        logic [29:0] nx;
        logic [29:0] ny;
    } sq_t;

    typedef struct packed {
        vec_t        v;
        logic        big;
        logic        lzero;
        logic [23:0] m;
        logic [23:0] remx;
        logic [23:0] remy;
        logic [15:0] qx;
        logic [15:0] qy;
        logic [7:0]  lx;
        logic [7:0]  ly;
    } dv_t;

    // one root bit per stage
    function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] bits);
        logic [26:0] r2;
        logic [26:0] test;
        sq_t         o;
        o    = s;
        r2   = {s.rem[24:0], bits};
        test = {1'b0, s.root, 2'b01};
        if (r2 >= test)
        begin
            o.rem  = r2 - test;
            o.root = {s.root[22:0], 1'b1};
        end
        else
        begin
            o.rem  = r2;
            o.root = {s.root[22:0], 1'b0};
        end
        return o;
    endfunction

    // one quotient bit per stage, both components side by side
    function automatic dv_t div_step(input dv_t d, input logic bx, input logic by);
        logic [24:0] r2x;
        logic [24:0] r2y;
        dv_t         o;
        o   = d;
        r2x = {d.remx, bx};
        r2y = {d.remy, by};
        if (r2x >= {1'b0, d.m})
        begin
            o.remx = 24'(r2x - {1'b0, d.m});
            o.qx   = {d.qx[14:0], 1'b1};
        end
        else
        begin
            o.remx = r2x[23:0];
            o.qx   = {d.qx[14:0], 1'b0};
        end
        if (r2y >= {1'b0, d.m})
        begin
            o.remy = 24'(r2y - {1'b0, d.m});
            o.qy   = {d.qy[14:0], 1'b1};
        end
        else
        begin
            o.remy = r2y[23:0];
            o.qy   = {d.qy[14:0], 1'b0};
        end
        return o;
    endfunction

    logic [15:0] magx;
    logic [15:0] magy;
    logic [29:0] limsq_reg;
    pre_t        pre_reg;
    pre_t        pre_next;
    logic        pre_vld_reg;
    sq_t         sq_reg  [0:SQ_STEPS];
    sq_t         sq_next [0:SQ_STEPS];
    logic        sq_vld_reg [0:SQ_STEPS];
    dv_t         dv_reg  [0:DIV_STEPS];
    dv_t         dv_next [0:DIV_STEPS];
    logic        dv_vld_reg [0:DIV_STEPS];
    vec_t        out_reg;
    vec_t        out_next;
    logic        out_vld_reg;

    // squared limit, follows the register
    always_ff @(posedge clk)
    begin
        limsq_reg <= 30'(30'(speed_limit) * 30'(speed_limit));
    end

    // squares and scaled numerators
    always_comb
    begin
        magx = in_vec.x[15] ? 16'(-in_vec.x) : 16'(in_vec.x);
        magy = in_vec.y[15] ? 16'(-in_vec.y) : 16'(in_vec.y);
        pre_next.v   = in_vec;
        pre_next.sqx = 31'(32'(magx) * 32'(magx));
        pre_next.sqy = 31'(32'(magy) * 32'(magy));
        pre_next.nx  = 30'(31'(magx) * 31'(speed_limit));
        pre_next.ny  = 30'(31'(magy) * 31'(speed_limit));
    end

    // square sum and limit compare
    always_comb
    begin
        sq_next[0].v     = pre_reg.v;
        sq_next[0].s2    = 32'(pre_reg.sqx) + 32'(pre_reg.sqy);
        sq_next[0].big   = sq_next[0].s2 >= 32'(limsq_reg);
        sq_next[0].lzero = speed_limit == 15'd0;
        sq_next[0].rem   = '0;
        sq_next[0].root  = '0;
        sq_next[0].nx    = pre_reg.nx;
        sq_next[0].ny    = pre_reg.ny;
    end

    // square root of s2 * 2^16
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        logic [47:0] rad;
        assign rad          = {sq_reg[k].s2, 16'd0};
        assign sq_next[k+1] = sqrt_step(sq_reg[k], rad[47-2*k -: 2]);
    end

    // divider set-up: numerator is n * 256, first 22 bits preloaded
    always_comb
    begin
        dv_next[0].v     = sq_reg[SQ_STEPS].v;
        dv_next[0].big   = sq_reg[SQ_STEPS].big;
        dv_next[0].lzero = sq_reg[SQ_STEPS].lzero;
        dv_next[0].m     = sq_reg[SQ_STEPS].root;
        dv_next[0].remx  = {2'b00, sq_reg[SQ_STEPS].nx[29:8]};
        dv_next[0].remy  = {2'b00, sq_reg[SQ_STEPS].ny[29:8]};
        dv_next[0].qx    = '0;
        dv_next[0].qy    = '0;
        dv_next[0].lx    = sq_reg[SQ_STEPS].nx[7:0];
        dv_next[0].ly    = sq_reg[SQ_STEPS].ny[7:0];
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        if (j < 8)
        begin : g_low
            assign dv_next[j+1] = div_step(dv_reg[j], dv_reg[j].lx[7-j], dv_reg[j].ly[7-j]);
        end
        else
        begin : g_zero
            assign dv_next[j+1] = div_step(dv_reg[j], 1'b0, 1'b0);
        end
    end

    // pick the original, shrunk or zero vector
    always_comb
    begin
        out_next = dv_reg[DIV_STEPS].v;
        if (dv_reg[DIV_STEPS].big)
        begin
            if (dv_reg[DIV_STEPS].lzero)
            begin
                out_next.x = '0;
                out_next.y = '0;
            end
            else
            begin
                out_next.x = dv_reg[DIV_STEPS].v.x[15] ? -$signed(dv_reg[DIV_STEPS].qx)
                                                       : $signed(dv_reg[DIV_STEPS].qx);
                out_next.y = dv_reg[DIV_STEPS].v.y[15] ? -$signed(dv_reg[DIV_STEPS].qy)
                                                       : $signed(dv_reg[DIV_STEPS].qy);
            end
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i <= SQ_STEPS; i++)
            begin
                sq_vld_reg[i] <= 1'b0;
            end
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                dv_vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            pre_vld_reg   <= in_valid;
            sq_vld_reg[0] <= pre_vld_reg;
            for (int i = 1; i <= SQ_STEPS; i++)
            begin
                sq_vld_reg[i] <= sq_vld_reg[i-1];
            end
            dv_vld_reg[0] <= sq_vld_reg[SQ_STEPS];
            for (int i = 1; i <= DIV_STEPS; i++)
            begin
                dv_vld_reg[i] <= dv_vld_reg[i-1];
            end
            out_vld_reg <= dv_vld_reg[DIV_STEPS];
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg <= pre_next;
            for (int i = 0; i <= SQ_STEPS; i++)
            begin
                sq_reg[i] <= sq_next[i];
            end
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                dv_reg[i] <= dv_next[i];
            end
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_vec   = out_reg;

endmodule

`default_nettype wire

// ===== rtl/gtfws_cordic.sv =====
// ----------------------------------------------------------------------------
// gtfws_cordic
// pipelined rotation by minus heading with gain correction
// ----------------------------------------------------------------------------
`default_nettype none

module gtfws_cordic #(
    parameter int STEPS = gtfws_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  wire logic                                  in_valid,
    input  wire gtfws_pkg::vec_t                       in_vec,
    output logic                                       out_valid,
    output logic signed [gtfws_pkg::PROJ_W-1:0]        radial,
    output logic signed [gtfws_pkg::PROJ_W-1:0]        tangential
);
    import gtfws_pkg::*;

    localparam int NST = (STEPS > CORDIC_TABLE_LEN) ? CORDIC_TABLE_LEN : STEPS;

    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [33:0] z;
    } rot_t;

    // one micro-rotation
    function automatic rot_t rot_step(input rot_t s, input int i);
        logic signed [35:0] dx;
        logic signed [35:0] dy;
        logic signed [33:0] at;
        rot_t               o;
        dx = s.y >>> i;
        dy = s.x >>> i;
        at = $signed({2'b00, atan_entry(i)});
        if (!s.z[33])
        begin
            o.x = s.x - dx;
            o.y = s.y + dy;
            o.z = s.z - at;
        end
        else
        begin
            o.x = s.x + dx;
            o.y = s.y - dy;
            o.z = s.z + at;
        end
        return o;
    endfunction

    logic [31:0]         ang;
    logic [31:0]         ang_off;
    logic [1:0]          quad;
    logic [31:0]         resid;
    logic signed [35:0]  xs;
    logic signed [35:0]  ys;
    rot_t                rot_reg  [0:NST];
    rot_t                rot_next [0:NST];
    logic                rot_vld_reg [0:NST];
    logic signed [16:0]  gain;
    logic signed [52:0]  prx;
    logic signed [52:0]  pry;
    logic signed [PROJ_W-1:0] r_reg;
    logic signed [PROJ_W-1:0] r_next;
    logic signed [PROJ_W-1:0] t_reg;
    logic signed [PROJ_W-1:0] t_next;
    logic                out_vld_reg;

    // whole quarter turns first, leaving a residual within an eighth turn
    always_comb
    begin
        ang     = 32'd0 - {in_vec.heading, 16'd0};
        ang_off = ang + 32'h2000_0000;
        quad    = ang_off[31:30];
        resid   = ang - {quad, 30'd0};
        xs      = {{4{in_vec.x[15]}}, in_vec.x, 16'd0};
        ys      = {{4{in_vec.y[15]}}, in_vec.y, 16'd0};
        rot_next[0].z = {{2{resid[31]}}, resid};
        case (quad)
            2'd1:
            begin
                rot_next[0].x = -ys;
                rot_next[0].y = xs;
            end
            2'd2:
            begin
                rot_next[0].x = -xs;
                rot_next[0].y = -ys;
            end
            2'd3:
            begin
                rot_next[0].x = ys;
                rot_next[0].y = -xs;
            end
            default:
            begin
                rot_next[0].x = xs;
                rot_next[0].y = ys;
            end
        endcase
    end

    for (genvar i = 0; i < NST; i++)
    begin : g_rot
        assign rot_next[i+1] = rot_step(rot_reg[i], i);
    end

    // gain removal and rounding to Q.8
    always_comb
    begin
        gain   = 17'(INV_GAIN);
        prx    = rot_reg[NST].x * gain;
        pry    = rot_reg[NST].y * gain;
        r_next = PROJ_W'((prx + 53'sd8388608) >>> 24);
        t_next = PROJ_W'((pry + 53'sd8388608) >>> 24);
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            for (int i = 0; i <= NST; i++)
            begin
                rot_vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            rot_vld_reg[0] <= in_valid;
            for (int i = 1; i <= NST; i++)
            begin
                rot_vld_reg[i] <= rot_vld_reg[i-1];
            end
            out_vld_reg <= rot_vld_reg[NST];
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= NST; i++)
            begin
                rot_reg[i] <= rot_next[i];
            end
            r_reg <= r_next;
            t_reg <= t_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign radial     = r_reg;
    assign tangential = t_reg;

endmodule

`default_nettype wire

// ===== rtl/gradient_to_four_wheel_speeds_core.sv =====
// ----------------------------------------------------------------------------
// gradient_to_four_wheel_speeds_core
// motion vector and heading in, four saturated wheel speeds out
// ----------------------------------------------------------------------------
// usage
//  - cmd takes one request (grad_x, grad_y, heading) per cycle unless speeds stalls; speeds
//    returns one request of four wheel speeds for each, in order
//  - each request passes the length limiter (24 root stages, 16 divide
//    stages), then the rotator, then the wheel mixer
//  - throughput is one request per cycle while speeds is not stalled; every stage is a register
//  - when speeds is stalled the whole pipeline holds and cmd.ready drops,
//    so nothing is lost or repeated; the output register keeps its request
//  - reset clears all stage valids and loads speed_limit = 1.0,
//    inv_circumference = 1.0 and zero levers
//  - cfg_we writes register cfg_index with cfg_data; indexes
//    six and seven are ignored; write only while the pipeline is empty
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gradient_to_four_wheel_speeds_core #(
    parameter int CORDIC_STEPS = gtfws_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    gtfws_cmd_if.sink                              cmd,
    gtfws_spd_if.source                            speeds,
    input  wire logic                              cfg_we,
    input  wire logic [gtfws_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gtfws_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gtfws_pkg::*;

    logic [14:0]         speed_limit_reg;
    logic [15:0]         inv_circ_reg;
    logic signed [15:0]  lever_reg [0:3];
    logic                advance;
    vec_t                cmd_vec;
    logic                lim_vld;
    vec_t                lim_vec;
    logic                rt_vld;
    logic signed [PROJ_W-1:0] rt_r;
    logic signed [PROJ_W-1:0] rt_t;
    logic                w1_vld_reg;
    logic signed [32:0]  w1_r100_reg;
    logic signed [29:0]  w1_p_reg [0:3];
    logic signed [29:0]  w1_p_next [0:3];
    logic                w2_vld_reg;
    logic signed [32:0]  w2_r100_reg;
    logic signed [34:0]  w2_w_reg [0:3];
    logic signed [34:0]  w2_w_next [0:3];
    logic                out_vld_reg;
    logic signed [23:0]  spd_reg [0:3];
    logic signed [23:0]  spd_next [0:3];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= SPEED_LIMIT_RST;
            inv_circ_reg    <= INV_CIRC_RST;
            for (int i = 0; i < 4; i++)
            begin
                lever_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_SPEED_LIMIT: speed_limit_reg <= cfg_data[14:0];
                REG_INV_CIRC:    inv_circ_reg    <= cfg_data;
                REG_FL_LEVER:    lever_reg[0]    <= $signed(cfg_data);
                REG_FR_LEVER:    lever_reg[1]    <= $signed(cfg_data);
                REG_BL_LEVER:    lever_reg[2]    <= $signed(cfg_data);
                REG_BR_LEVER:    lever_reg[3]    <= $signed(cfg_data);
                default:         ;
            endcase
        end
    end

    // global pipeline enable: move while the output register can take a request
    assign advance   = !out_vld_reg || speeds.ready;
    assign cmd.ready = advance;

    assign cmd_vec.x       = cmd.grad_x;
    assign cmd_vec.y       = cmd.grad_y;
    assign cmd_vec.heading = cmd.heading;

    gtfws_limit u_limit (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .in_valid    (cmd.valid),
        .in_vec      (cmd_vec),
        .speed_limit (speed_limit_reg),
        .out_valid   (lim_vld),
        .out_vec     (lim_vec)
    );

    gtfws_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .in_valid   (lim_vld),
        .in_vec     (lim_vec),
        .out_valid  (rt_vld),
        .radial     (rt_r),
        .tangential (rt_t)
    );

    // wheel terms: lever products, then circumference scaling, then sum
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            w1_p_next[k] = 30'((42'(rt_t) * 42'(lever_reg[k])) >>> 12);
            w2_w_next[k] = 35'((47'(w1_p_reg[k]) * 47'($signed({1'b0, inv_circ_reg}))) >>> 12);
            spd_next[k]  = '0;
        end
        for (int k = 0; k < 4; k++)
        begin
            logic signed [35:0] sum;
            logic signed [27:0] sc;
            sum = 36'(w2_r100_reg) + 36'(w2_w_reg[k]) + 36'sd128;
            sc  = 28'(sum >>> 8);
            if (sc > 28'sd8388607)
            begin
                spd_next[k] = 24'sh7FFFFF;
            end
            else if (sc < -28'sd8388608)
            begin
                spd_next[k] = 24'sh800000;
            end
            else
            begin
                spd_next[k] = sc[23:0];
            end
        end
    end

    // mixer stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_vld_reg  <= 1'b0;
            w2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            w1_vld_reg  <= rt_vld;
            w2_vld_reg  <= w1_vld_reg;
            out_vld_reg <= w2_vld_reg;
        end
    end

    // mixer stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            w1_r100_reg <= 33'(rt_r) * 33'sd100;
            w2_r100_reg <= w1_r100_reg;
            for (int k = 0; k < 4; k++)
            begin
                w1_p_reg[k] <= w1_p_next[k];
                w2_w_reg[k] <= w2_w_next[k];
                spd_reg[k]  <= spd_next[k];
            end
        end
    end

    assign speeds.valid             = out_vld_reg;
    assign speeds.front_left_speed  = spd_reg[0];
    assign speeds.front_right_speed = spd_reg[1];
    assign speeds.back_left_speed   = spd_reg[2];
    assign speeds.back_right_speed  = spd_reg[3];

    // a stall freezes the inner stages
    `ASSERT_NEXT(a_stall_holds_mixer, clk, rst_n, out_vld_reg && !speeds.ready, $stable(w2_vld_reg))
    `ASSERT_NEXT(a_stall_holds_rotator, clk, rst_n, out_vld_reg && !speeds.ready, $stable(rt_vld))
    // a moving request reaches the output register
    `ASSERT_NEXT(a_mixer_to_output, clk, rst_n, w2_vld_reg && advance, out_vld_reg)

endmodule

`default_nettype wire
